/* rtl/core/sensor_frame_decimal_parser_macros.svh */
// Assertion macros for the sensor frame decimal parser checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef SENSOR_FRAME_DECIMAL_PARSER_MACROS_SVH
`define SENSOR_FRAME_DECIMAL_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sfdp_pkg.sv */
// Package for the sensor frame decimal parser: sync and index codes,
// reciprocal constants and the structs passed between stages. No dependencies.
package sfdp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h42;
  localparam logic [7:0] SYNC_SECOND = 8'h4d;

  localparam logic [1:0] PHASE_HUNT    = 2'd0;
  localparam logic [1:0] PHASE_SYNC2   = 2'd1;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

  localparam logic [2:0] IDX_SCALE = 3'd3;
  localparam logic [2:0] IDX_HIGH  = 3'd4;
  localparam logic [2:0] IDX_LOW   = 3'd5;
  localparam logic [2:0] IDX_LAST  = 3'd7;

  localparam logic [7:0] SCALE_X1    = 8'd1;
  localparam logic [7:0] SCALE_X10   = 8'd2;
  localparam logic [7:0] SCALE_X100  = 8'd3;
  localparam logic [7:0] SCALE_X1000 = 8'd4;

  // floor(x / d) = (x * RECIP) >> SHIFT, exact for any 16-bit x
  localparam logic [32:0] RECIP10   = 33'd52429;
  localparam logic [32:0] RECIP100  = 33'd83887;
  localparam logic [32:0] RECIP1000 = 33'd67109;

  typedef struct packed {
    logic [15:0] raw;
    logic [7:0]  scale;
  } frame_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [7:0]  scale;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1000;
  } quot_t;

  typedef struct packed {
    logic advance;
  } stage_ctl_t;

endpackage

/* rtl/core/sfdp_framer.sv */
// Sync hunt and payload capture for the sensor frame decimal parser.
// Depends on sfdp_pkg; flags the transfer of the last payload byte.
module sfdp_framer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output logic            done_o,
  output sfdp_pkg::frame_t frame_o
);
  import sfdp_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [2:0] count_q, count_d;
  logic [7:0] scale_q, high_q, low_q;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    done_o  = 1'b0;
    if (accept_i) begin
      case (phase_q)
        PHASE_SYNC2: begin
          phase_d = (rx_byte_i == SYNC_SECOND) ? PHASE_PAYLOAD : PHASE_HUNT;
          count_d = 3'd0;
        end
        PHASE_PAYLOAD: begin
          if (count_q == IDX_LAST) begin
            phase_d = PHASE_HUNT;
            count_d = 3'd0;
            done_o  = 1'b1;
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        default: begin
          phase_d = (rx_byte_i == SYNC_FIRST) ? PHASE_SYNC2 : PHASE_HUNT;
          count_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_HUNT;
      count_q <= 3'd0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && phase_q == PHASE_PAYLOAD) begin
      if (count_q == IDX_SCALE) scale_q <= rx_byte_i;
      if (count_q == IDX_HIGH)  high_q  <= rx_byte_i;
      if (count_q == IDX_LOW)   low_q   <= rx_byte_i;
    end
  end

  assign frame_o.raw   = {high_q, low_q};
  assign frame_o.scale = scale_q;

endmodule

/* rtl/core/sfdp_divider.sv */
// Quotient stage: divides the reading by 10, 100 and 1000 with reciprocals.
// Depends on sfdp_pkg; holds one frame until the result stage takes it.
module sfdp_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  sfdp_pkg::frame_t     frame_i,
  input  logic                 out_free_i,
  output logic                 ready_o,
  output sfdp_pkg::stage_ctl_t ctl_o,
  output sfdp_pkg::quot_t      quot_o
);
  import sfdp_pkg::*;

  logic        valid_q, valid_d;
  quot_t       quot_q;
  logic [32:0] p10, p100, p1000;

  assign p10   = {17'd0, frame_i.raw} * RECIP10;
  assign p100  = {17'd0, frame_i.raw} * RECIP100;
  assign p1000 = {17'd0, frame_i.raw} * RECIP1000;

  assign ctl_o.advance = valid_q && out_free_i;
  assign ready_o       = !valid_q || out_free_i;

  always_comb begin
    valid_d = valid_q;
    if (ctl_o.advance) valid_d = 1'b0;
    if (load_i)        valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quot_q.raw   <= frame_i.raw;
      quot_q.scale <= frame_i.scale;
      quot_q.q10   <= p10[31:19];
      quot_q.q100  <= p100[32:23];
      quot_q.q1000 <= p1000[32:26];
    end
  end

  assign quot_o = quot_q;

endmodule

/* rtl/core/sfdp_result.sv */
// Result stage: selects whole part and hundredths, saturates, repeats on
// an unknown scale code. Depends on sfdp_pkg; owns the output register.
module sfdp_result (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfdp_pkg::stage_ctl_t ctl_i,
  input  sfdp_pkg::quot_t      quot_i,
  input  logic                 out_ready_i,
  output logic                 out_free_o,
  output logic                 out_valid_o,
  output logic [7:0]           integer_part_o,
  output logic [6:0]           hundredths_o,
  output logic                 saturated_o,
  output logic [15:0]          raw_reading_o,
  output logic                 scale_known_o
);
  import sfdp_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  last_integer_q;
  logic [6:0]  last_hundredths_q;
  logic        last_saturated_q;
  logic [15:0] raw_reading_q;
  logic        scale_known_q;

  logic        known;
  logic [15:0] whole;
  logic [15:0] frac;

  always_comb begin
    known = 1'b1;
    whole = quot_i.raw;
    frac  = 16'd0;
    case (quot_i.scale)
      SCALE_X1: begin
        whole = quot_i.raw;
        frac  = 16'd0;
      end
      SCALE_X10: begin
        whole = {3'd0, quot_i.q10};
        frac  = (quot_i.raw - {3'd0, quot_i.q10} * 16'd10) * 16'd10;
      end
      SCALE_X100: begin
        whole = {6'd0, quot_i.q100};
        frac  = quot_i.raw - {6'd0, quot_i.q100} * 16'd100;
      end
      SCALE_X1000: begin
        whole = {9'd0, quot_i.q1000};
        frac  = {3'd0, quot_i.q10} - {9'd0, quot_i.q1000} * 16'd100;
      end
      default: known = 1'b0;
    endcase
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i)   out_valid_d = 1'b0;
    if (ctl_i.advance) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q       <= 1'b0;
      last_integer_q    <= 8'd0;
      last_hundredths_q <= 7'd0;
      last_saturated_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctl_i.advance && known) begin
        last_integer_q    <= (whole > 16'd255) ? 8'd255 : whole[7:0];
        last_saturated_q  <= (whole > 16'd255);
        last_hundredths_q <= frac[6:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      raw_reading_q <= quot_i.raw;
      scale_known_q <= known;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign integer_part_o = last_integer_q;
  assign hundredths_o   = last_hundredths_q;
  assign saturated_o    = last_saturated_q;
  assign raw_reading_o  = raw_reading_q;
  assign scale_known_o  = scale_known_q;

endmodule

/* rtl/core/sensor_frame_decimal_parser.sv */
// Top level of the sensor frame decimal parser: framer, quotient stage and
// result stage. Depends on sfdp_pkg, sfdp_framer, sfdp_divider, sfdp_result.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   input    | in_valid_i, in_ready_o | rx_byte_i
//   output   | out_valid_o, out_ready_i | integer_part_o, hundredths_o,
//            |                        | saturated_o, raw_reading_o, scale_known_o
//
// One byte per cycle while in_ready_o is high; a frame is ten bytes at the least.
// The quotient register loads at the edge that transfers the last payload byte;
// the result register then takes the result once it is free.
// in_ready_o drops only while both the quotient and result registers are full
// and out_ready_i is low.
// Reset clears the sync hunt, payload count and last values to zero.
module sensor_frame_decimal_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  integer_part_o,
  output logic [6:0]  hundredths_o,
  output logic        saturated_o,
  output logic [15:0] raw_reading_o,
  output logic        scale_known_o
);
  import sfdp_pkg::*;

  logic       accept;
  logic       done;
  logic       out_free;
  frame_t     frame;
  quot_t      quot;
  stage_ctl_t ctl;

  assign accept = in_valid_i && in_ready_o;

  sfdp_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .done_o    (done),
    .frame_o   (frame)
  );

  sfdp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (done),
    .frame_i    (frame),
    .out_free_i (out_free),
    .ready_o    (in_ready_o),
    .ctl_o      (ctl),
    .quot_o     (quot)
  );

  sfdp_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .quot_i         (quot),
    .out_ready_i    (out_ready_i),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .integer_part_o (integer_part_o),
    .hundredths_o   (hundredths_o),
    .saturated_o    (saturated_o),
    .raw_reading_o  (raw_reading_o),
    .scale_known_o  (scale_known_o)
  );

endmodule

/* rtl/core/sfdp_checker.sv */
// Port-level checker for the sensor frame decimal parser, bound to the top.
// Depends on sensor_frame_decimal_parser_macros.svh.
`include "sensor_frame_decimal_parser_macros.svh"

module sfdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  integer_part_o,
  input logic [6:0]  hundredths_o,
  input logic        saturated_o,
  input logic [15:0] raw_reading_o,
  input logic        scale_known_o
);

  logic        out_stall;
  logic        range_ok;
  logic [32:0] result_bits;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign range_ok    = (hundredths_o <= 7'd99) && (!saturated_o || integer_part_o == 8'd255);
  assign result_bits = {integer_part_o, hundredths_o, saturated_o, raw_reading_o,
                        scale_known_o};

  `SFDP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "result dropped while stalled")
  `SFDP_ASSERT_NEXT(a_out_stable, out_stall, $stable(result_bits), "result changed while stalled")
  `SFDP_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o, "input stalled with no result")
  `SFDP_ASSERT_NOW(a_result_range, out_valid_o, range_ok, "result out of range")

endmodule

bind sensor_frame_decimal_parser sfdp_checker u_checker (.*);

/* sim/sensor_frame_decimal_parser_test.sv */
// Testbench for sensor_frame_decimal_parser: directed frame table, then random frames,
// broken sync attempts and noise, scored against a byte-level parser model.
// Depends on sfdp_pkg and the sensor_frame_decimal_parser RTL.
`timescale 1ns / 100ps

module sensor_frame_decimal_parser_test;
  import sfdp_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 570;
  localparam int unsigned NUM_ROWS = 18;

  typedef struct packed {
    logic [7:0]  integer_part;
    logic [6:0]  hundredths;
    logic        saturated;
    logic [15:0] raw_reading;
    logic        scale_known;
  } reading_t;

  typedef struct packed {
    logic [7:0]  second;
    logic [7:0]  scale;
    logic [15:0] raw;
    logic [7:0]  fill;
    logic        typed;
    reading_t    want;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  integer_part;
  logic [6:0]  hundredths;
  logic        saturated;
  logic [15:0] raw_reading;
  logic        scale_known;

  logic [1:0]  sync_phase;
  logic [2:0]  payload_count;
  logic [7:0]  scale_byte;
  logic [7:0]  reading_high;
  logic [7:0]  reading_low;
  logic [7:0]  last_integer;
  logic [6:0]  last_hundredths;
  logic        last_saturated;

  reading_t    pending_readings[$];
  reading_t    typed_reading;
  bit          typed_armed;
  bit          steady;
  int unsigned fail_count;
  int unsigned idle_cycles;

  frame_row_t  directed_rows [NUM_ROWS];
  logic [15:0] corner_raw [8];

  sensor_frame_decimal_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .integer_part_o (integer_part),
    .hundredths_o   (hundredths),
    .saturated_o    (saturated),
    .raw_reading_o  (raw_reading),
    .scale_known_o  (scale_known)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit parse_byte(input logic [7:0] b, output reading_t r);
    int unsigned raw;
    int unsigned divisor;
    int unsigned whole;
    bit          known;
    r = '0;
    case (sync_phase)
      PHASE_SYNC2: begin
        if (b == SYNC_SECOND) begin
          sync_phase = PHASE_PAYLOAD;
          payload_count = '0;
        end else begin
          sync_phase = PHASE_HUNT;
        end
        return 1'b0;
      end
      PHASE_PAYLOAD: begin
        if (payload_count == IDX_SCALE) scale_byte = b;
        if (payload_count == IDX_HIGH) reading_high = b;
        if (payload_count == IDX_LOW) reading_low = b;
        if (payload_count != IDX_LAST) begin
          payload_count = payload_count + 3'd1;
          return 1'b0;
        end
        sync_phase = PHASE_HUNT;
        payload_count = '0;
        raw = {reading_high, reading_low};
        known = 1'b1;
        divisor = 1;
        case (scale_byte)
          SCALE_X1:    divisor = 1;
          SCALE_X10:   divisor = 10;
          SCALE_X100:  divisor = 100;
          SCALE_X1000: divisor = 1000;
          default:     known = 1'b0;
        endcase
        if (known) begin
          whole = raw / divisor;
          last_saturated = (whole > 255);
          last_integer = (whole > 255) ? 8'd255 : whole[7:0];
          last_hundredths = 7'(((raw % divisor) * 100) / divisor);
        end
        r.integer_part = last_integer;
        r.hundredths = last_hundredths;
        r.saturated = last_saturated;
        r.raw_reading = raw[15:0];
        r.scale_known = known;
        return 1'b1;
      end
      default: begin
        sync_phase = (b == SYNC_FIRST) ? PHASE_SYNC2 : PHASE_HUNT;
        payload_count = '0;
        return 1'b0;
      end
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        if (parse_byte(rx_byte, got)) begin
          if (typed_armed) begin
            pending_readings.push_back(typed_reading);
            typed_armed = 1'b0;
          end else begin
            pending_readings.push_back(got);
          end
        end
      end
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          if (integer_part !== want.integer_part) begin
            $error("integer_part: expected %0d, got %0d", want.integer_part, integer_part);
            fail_count++;
          end
          if (hundredths !== want.hundredths) begin
            $error("hundredths: expected %0d, got %0d", want.hundredths, hundredths);
            fail_count++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, saturated);
            fail_count++;
          end
          if (raw_reading !== want.raw_reading) begin
            $error("raw_reading: expected %h, got %h", want.raw_reading, raw_reading);
            fail_count++;
          end
          if (scale_known !== want.scale_known) begin
            $error("scale_known: expected %0d, got %0d", want.scale_known, scale_known);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sensor_frame_decimal_parser regression: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_frame(input logic [7:0] second, input logic [7:0] scale,
                            input logic [15:0] raw, input logic [7:0] fill,
                            input bit scatter);
    send_byte(SYNC_FIRST);
    send_byte(second);
    for (int i = 0; i < 8; i++) begin
      if (i == IDX_SCALE) send_byte(scale);
      else if (i == IDX_HIGH) send_byte(raw[15:8]);
      else if (i == IDX_LOW) send_byte(raw[7:0]);
      else send_byte(scatter ? 8'($urandom_range(0, 255)) : fill);
    end
  endtask

  initial begin
    logic [7:0]  second;
    logic [7:0]  scale;
    logic [15:0] raw;
    int unsigned sent;
    int unsigned pick;

    rst_ni = 1'b0;
    in_valid = 1'b0;
    rx_byte = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    typed_armed = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    sync_phase = PHASE_HUNT;
    payload_count = '0;
    scale_byte = '0;
    reading_high = '0;
    reading_low = '0;
    last_integer = '0;
    last_hundredths = '0;
    last_saturated = 1'b0;

    corner_raw = '{16'd0, 16'd255, 16'd256, 16'd2559, 16'd2560, 16'd25599, 16'd25600,
                   16'hffff};
    directed_rows = '{
      '{SYNC_SECOND, 8'd0,        16'h1234, 8'h00, 1'b1, '{8'd0,   7'd0,  1'b0, 16'h1234, 1'b0}},
      '{SYNC_SECOND, SCALE_X1,    16'h0000, 8'hff, 1'b1, '{8'd0,   7'd0,  1'b0, 16'h0000, 1'b1}},
      '{SYNC_SECOND, SCALE_X1,    16'hffff, 8'h00, 1'b1, '{8'd255, 7'd0,  1'b1, 16'hffff, 1'b1}},
      '{SYNC_SECOND, SCALE_X1,    16'h00ff, 8'hff, 1'b1, '{8'd255, 7'd0,  1'b0, 16'h00ff, 1'b1}},
      '{SYNC_SECOND, SCALE_X1,    16'h0100, 8'h00, 1'b1, '{8'd255, 7'd0,  1'b1, 16'h0100, 1'b1}},
      '{SYNC_SECOND, SCALE_X10,   16'hffff, 8'h00, 1'b1, '{8'd255, 7'd50, 1'b1, 16'hffff, 1'b1}},
      '{SYNC_SECOND, SCALE_X10,   16'h09ff, 8'h00, 1'b1, '{8'd255, 7'd90, 1'b0, 16'h09ff, 1'b1}},
      '{SYNC_SECOND, SCALE_X100,  16'h3039, 8'h00, 1'b1, '{8'd123, 7'd45, 1'b0, 16'h3039, 1'b1}},
      '{SYNC_SECOND, SCALE_X1000, 16'hffff, 8'h00, 1'b1, '{8'd65,  7'd53, 1'b0, 16'hffff, 1'b1}},
      '{SYNC_SECOND, SCALE_X1000, 16'h03e7, 8'h00, 1'b1, '{8'd0,   7'd99, 1'b0, 16'h03e7, 1'b1}},
      '{SYNC_SECOND, 8'hff,       16'ha5a5, 8'h00, 1'b1, '{8'd0,   7'd99, 1'b0, 16'ha5a5, 1'b0}},
      '{SYNC_SECOND, 8'd5,        16'h5a5a, 8'hff, 1'b0, '0},
      '{SYNC_FIRST,  SYNC_SECOND, 16'h4d4d, 8'h4d, 1'b0, '0},
      '{8'h00,       SCALE_X1,    16'h0001, 8'h00, 1'b0, '0},
      '{8'hff,       SCALE_X10,   16'hffff, 8'hff, 1'b0, '0},
      '{SYNC_SECOND, SCALE_X10,   16'h4d42, 8'h42, 1'b0, '0},
      '{SYNC_SECOND, SCALE_X100,  16'h6400, 8'h4d, 1'b0, '0},
      '{SYNC_SECOND, SCALE_X1,    16'h8001, 8'h55, 1'b0, '0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      typed_reading = directed_rows[i].want;
      typed_armed = directed_rows[i].typed;
      send_frame(directed_rows[i].second, directed_rows[i].scale, directed_rows[i].raw,
                 directed_rows[i].fill, 1'b0);
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      steady = (sent >= 250 && sent < 450);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        pick = $urandom_range(1, 4);
        repeat (pick) send_byte(8'($urandom_range(0, 255)));
        sent += pick;
      end else if (pick < 18) begin
        second = 8'($urandom_range(0, 255));
        if (second == SYNC_SECOND) second = SYNC_FIRST;
        send_frame(second, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   8'h00, 1'b1);
        sent += 10;
      end else begin
        scale = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 4))
                                             : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40) raw = 16'($urandom_range(0, 65535));
        else if (pick < 70) raw = 16'($urandom_range(0, 2600));
        else if (pick < 85) raw = corner_raw[$urandom_range(0, 7)];
        else raw = 16'($urandom_range(0, 26000));
        send_frame(SYNC_SECOND, scale, raw, 8'h00, 1'b1);
        sent += 10;
      end
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sensor_frame_decimal_parser regression: pass");
    end else begin
      $display("sensor_frame_decimal_parser regression: fail");
    end
    $finish;
  end

endmodule
